/* sv/amc_pkg.sv */
`default_nettype none

package amc_pkg;

  // Table geometry
  localparam int DEF_ENTRIES = 32;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int VICT_W   = 5;
  localparam int SLOT_W   = 5;
  localparam int KIND_W   = 2;
  localparam int EXP_W    = 6;
  localparam int AGE_W    = 8;

  localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd15;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_TICK   = 2'd2
  } func_t;

  // Insert outcome codes
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_FILL   = 2'd2,
    KIND_VICTIM = 2'd3
  } kind_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;  // capture input word, clear scan state
    logic scan;  // issue read at scan address, advance
    logic fin;   // commit insert, load result registers
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_done;  // every slot address issued
  } ctl_sts_t;

endpackage

`default_nettype wire

/* sv/address_map_cache_with_aging_unit.sv */
`default_nettype none

// IPv4-to-MAC address cache with aging. Each input word carries an operation:
// lookup (returns hit, the MAC and slot of the lowest valid matching entry),
// insert (refreshes a matching entry, else fills the lowest free slot, else
// overwrites slot victim_index modulo ENTRIES; reports which), or tick (ages
// every valid entry by one, saturating at 255, and drops entries whose age
// then exceeds max_age; reports how many). Every word yields exactly one
// result word. One word is in work at a time: the controller accepts it and
// walks the table once, one slot per cycle, through the single read port of
// each entry memory, whose read data is registered; it then commits the
// word and loads the result registers once the output register is free
// to take them. A finished result sits in an output register,
// so the next word is taken while it waits. max_age (reset 15) is written on
// the cfg port, which is always ready; write it only while no word is in
// flight. Valid flags clear at reset; there is no clearing pass.

module address_map_cache_with_aging_unit #(
  parameter int ENTRIES = amc_pkg::DEF_ENTRIES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  // operation words
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [amc_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [amc_pkg::IP_W-1:0]    in_ip_addr,
  input  wire logic [amc_pkg::MAC_W-1:0]   in_mac_addr,
  input  wire logic [amc_pkg::VICT_W-1:0]  in_victim_index,

  // result words
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic [amc_pkg::MAC_W-1:0]        out_mac_out,
  output logic [amc_pkg::SLOT_W-1:0]       out_slot,
  output logic [amc_pkg::KIND_W-1:0]       out_insert_kind,
  output logic [amc_pkg::EXP_W-1:0]        out_expired_count,

  // max_age register write
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [amc_pkg::AGE_W-1:0]   cfg_max_age
);

  amc_pkg::ctl_cmd_t cmd;
  amc_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer: idle -> scan all slots -> commit/emit
  amc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Entry memories, valid flags, scan pipeline, result registers
  amc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_max_age       (cfg_max_age),
    .in_func           (in_func),
    .in_ip_addr        (in_ip_addr),
    .in_mac_addr       (in_mac_addr),
    .in_victim_index   (in_victim_index),
    .out_hit           (out_hit),
    .out_mac_out       (out_mac_out),
    .out_slot          (out_slot),
    .out_insert_kind   (out_insert_kind),
    .out_expired_count (out_expired_count)
  );

endmodule

`default_nettype wire

/* sv/amc_ctrl.sv */
`default_nettype none

module amc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output amc_pkg::ctl_cmd_t       cmd,
  input  wire amc_pkg::ctl_sts_t  sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !(out_valid_r && out_stall);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.fin ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/amc_dp.sv */
`default_nettype none

module amc_dp #(
  parameter int ENTRIES = amc_pkg::DEF_ENTRIES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire amc_pkg::ctl_cmd_t             cmd,
  output amc_pkg::ctl_sts_t                  sts,
  input  wire logic                          cfg_we,
  input  wire logic [amc_pkg::AGE_W-1:0]     cfg_max_age,
  input  wire logic [amc_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [amc_pkg::IP_W-1:0]      in_ip_addr,
  input  wire logic [amc_pkg::MAC_W-1:0]     in_mac_addr,
  input  wire logic [amc_pkg::VICT_W-1:0]    in_victim_index,
  output logic                               out_hit,
  output logic [amc_pkg::MAC_W-1:0]          out_mac_out,
  output logic [amc_pkg::SLOT_W-1:0]         out_slot,
  output logic [amc_pkg::KIND_W-1:0]         out_insert_kind,
  output logic [amc_pkg::EXP_W-1:0]          out_expired_count
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int VICT_N = 2 ** amc_pkg::VICT_W;
  localparam int AGE_W  = amc_pkg::AGE_W;
  localparam int IP_W   = amc_pkg::IP_W;
  localparam int MAC_W  = amc_pkg::MAC_W;
  localparam int SLOT_W = amc_pkg::SLOT_W;
  localparam int EXP_W  = amc_pkg::EXP_W;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [EXP_W-1:0] EXP_MAX = '1;

  // Operation word
  logic [amc_pkg::FUNC_W-1:0] func_r;
  logic [IP_W-1:0]            ip_r;
  logic [MAC_W-1:0]           mac_r;
  logic [amc_pkg::VICT_W-1:0] victim_r;
  logic [AGE_W-1:0]           max_age_r;

  // Entry storage
  logic [ENTRIES-1:0] valid_r;
  logic [IP_W-1:0]    ip_mem  [ENTRIES];
  logic [MAC_W-1:0]   mac_mem [ENTRIES];
  logic [AGE_W-1:0]   age_mem [ENTRIES];

  // Scan pipeline: address stage, then registered read data stage
  logic [CNT_W-1:0]  addr_r;
  logic [IDX_W-1:0]  rd_idx;
  logic              dvld_r;
  logic [IDX_W-1:0]  didx_r;
  logic [IP_W-1:0]   ip_q_r;
  logic [MAC_W-1:0]  mac_q_r;
  logic [AGE_W-1:0]  age_q_r;

  // Scan results
  logic              found_r;
  logic [IDX_W-1:0]  found_idx_r;
  logic [MAC_W-1:0]  found_mac_r;
  logic              free_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [EXP_W-1:0]  exp_cnt_r;

  // Victim slot reduction, built at elaboration
  logic [IDX_W-1:0]  vmod [VICT_N];

  for (genvar g = 0; g < VICT_N; g++) begin : g_vmod
    assign vmod[g] = IDX_W'(g % ENTRIES);
  end

  logic              is_lookup, is_insert, is_tick;
  logic              d_valid, d_match;
  logic [AGE_W-1:0]  age_inc;
  logic              tick_wr, tick_kill;
  logic              ins_we;
  logic [IDX_W-1:0]  ins_idx;
  amc_pkg::kind_t    ins_kind;
  logic [IDX_W-1:0]  wr_idx;
  logic [AGE_W-1:0]  age_wdata;

  assign is_lookup = (func_r == amc_pkg::FN_LOOKUP);
  assign is_insert = (func_r == amc_pkg::FN_INSERT);
  assign is_tick   = (func_r == amc_pkg::FN_TICK);

  assign rd_idx        = addr_r[IDX_W-1:0];
  assign sts.scan_done = (addr_r == CNT_W'(ENTRIES));

  always_comb begin
    d_valid   = valid_r[didx_r];
    d_match   = d_valid && (ip_q_r == ip_r);
    age_inc   = (age_q_r == AGE_MAX) ? AGE_MAX : age_q_r + 8'd1;
    tick_wr   = dvld_r && is_tick && d_valid;
    tick_kill = tick_wr && (age_inc > max_age_r);

    if (found_r) begin
      ins_idx  = found_idx_r;
      ins_kind = amc_pkg::KIND_UPDATE;
    end else if (free_r) begin
      ins_idx  = free_idx_r;
      ins_kind = amc_pkg::KIND_FILL;
    end else begin
      ins_idx  = vmod[victim_r];
      ins_kind = amc_pkg::KIND_VICTIM;
    end
    ins_we = cmd.fin && is_insert;

    wr_idx    = ins_we ? ins_idx : didx_r;
    age_wdata = ins_we ? '0 : age_inc;
  end

  // Registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      ip_r     <= in_ip_addr;
      mac_r    <= in_mac_addr;
      victim_r <= in_victim_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= amc_pkg::MAX_AGE_RESET;
    end else if (cfg_we) begin
      max_age_r <= cfg_max_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (tick_kill) begin
        valid_r[didx_r] <= 1'b0;
      end
      if (ins_we) begin
        valid_r[ins_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      dvld_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.scan) begin
        addr_r <= addr_r + 1'b1;
      end
      dvld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= rd_idx;
  end

  // Memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (ins_we) begin
      ip_mem[wr_idx] <= ip_r;
    end
    ip_q_r <= ip_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (ins_we) begin
      mac_mem[wr_idx] <= mac_r;
    end
    mac_q_r <= mac_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (ins_we || tick_wr) begin
      age_mem[wr_idx] <= age_wdata;
    end
    age_q_r <= age_mem[rd_idx];
  end

  // Scan result collection, first hit / first free slot wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      free_r    <= 1'b0;
      exp_cnt_r <= '0;
    end else if (cmd.load) begin
      found_r   <= 1'b0;
      free_r    <= 1'b0;
      exp_cnt_r <= '0;
    end else if (dvld_r) begin
      if (d_match && !found_r) begin
        found_r <= 1'b1;
      end
      if (!d_valid && !free_r) begin
        free_r <= 1'b1;
      end
      if (tick_kill && (exp_cnt_r != EXP_MAX)) begin
        exp_cnt_r <= exp_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dvld_r && d_match && !found_r) begin
      found_idx_r <= didx_r;
      found_mac_r <= mac_q_r;
    end
    if (dvld_r && !d_valid && !free_r) begin
      free_idx_r <= didx_r;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_hit           <= is_lookup && found_r;
      out_mac_out       <= (is_lookup && found_r) ? found_mac_r : '0;
      out_insert_kind   <= is_insert ? ins_kind : amc_pkg::KIND_NONE;
      out_expired_count <= is_tick ? exp_cnt_r : '0;
      if (is_lookup && found_r) begin
        out_slot <= SLOT_W'(found_idx_r);
      end else if (is_insert) begin
        out_slot <= SLOT_W'(ins_idx);
      end else begin
        out_slot <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/address_map_cache_with_aging_unit_tb.sv */
`timescale 1ns / 1ps

module address_map_cache_with_aging_unit_tb;

  localparam int FUNC_W = amc_pkg::FUNC_W;
  localparam int IP_W   = amc_pkg::IP_W;
  localparam int MAC_W  = amc_pkg::MAC_W;
  localparam int VICT_W = amc_pkg::VICT_W;
  localparam int SLOT_W = amc_pkg::SLOT_W;
  localparam int KIND_W = amc_pkg::KIND_W;
  localparam int EXP_W  = amc_pkg::EXP_W;
  localparam int AGE_W  = amc_pkg::AGE_W;

  // func code 3 is not part of func_t; the block must treat it as a no-op
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam int          NENT        = amc_pkg::DEF_ENTRIES;
  localparam int          NDIR        = 15;
  localparam int          POOL_SZ     = 48;   // a bit over the table size, so victims happen
  localparam int          NPHASE      = 5;
  localparam int          PHASE_ITEMS = 95;
  localparam int          SAT_TICKS   = 258;  // past the 255 ceiling of an age
  localparam int          LONG_HOLD   = 400;  // receiver hold-off, in cycles
  localparam int          SETTLE_CYC  = 40;   // settle time after the last result word, in cycles
  localparam int          MAX_REPORTS = 10;
  localparam longint      LIMIT_NS    = 1_200_000;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [VICT_W-1:0] victim;
  } op_word_t;

  typedef struct packed {
    logic              hit;
    logic [MAC_W-1:0]  mac;
    logic [SLOT_W-1:0] slot;
    logic [KIND_W-1:0] kind;
    logic [EXP_W-1:0]  expired;
  } res_word_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct packed {
    op_word_t  w;
    logic      typed;
    res_word_t res;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time 0
  // ---------------------------------------------------------------------------
  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func         = '0;
  logic [IP_W-1:0]   in_ip_addr      = '0;
  logic [MAC_W-1:0]  in_mac_addr     = '0;
  logic [VICT_W-1:0] in_victim_index = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic              out_hit;
  logic [MAC_W-1:0]  out_mac_out;
  logic [SLOT_W-1:0] out_slot;
  logic [KIND_W-1:0] out_insert_kind;
  logic [EXP_W-1:0]  out_expired_count;
  logic              cfg_valid       = 1'b0;
  logic              cfg_ready;
  logic [AGE_W-1:0]  cfg_max_age     = amc_pkg::MAX_AGE_RESET;

  address_map_cache_with_aging_unit #(
    .ENTRIES(NENT)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_ip_addr       (in_ip_addr),
    .in_mac_addr      (in_mac_addr),
    .in_victim_index  (in_victim_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_mac_out      (out_mac_out),
    .out_slot         (out_slot),
    .out_insert_kind  (out_insert_kind),
    .out_expired_count(out_expired_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_age      (cfg_max_age)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache table and the max_age register
  // ---------------------------------------------------------------------------
  logic             shadow_valid [NENT];
  logic [IP_W-1:0]  shadow_ip    [NENT];
  logic [MAC_W-1:0] shadow_mac   [NENT];
  logic [AGE_W-1:0] shadow_age   [NENT];
  logic [AGE_W-1:0] shadow_max_age;

  res_word_t        pending_results [$];   // expected result words, oldest first
  int               mismatch_cnt = 0;

  logic [IP_W-1:0]  ip_pool [POOL_SZ];
  dir_row_t         dir_tab [NDIR];

  // receiver hold-off request: the stimulus flips it, the receiver reacts
  logic             hold_tgl = 1'b0;
  logic             hold_seen = 1'b0;
  int               hold_left = 0;
  int               rx_run_left = 0;
  logic             rx_run_stall = 1'b0;
  int               rx_pick;
  int               tx_burst_left = 0;

  res_word_t        got_res, want_res;

  // Applies one word to the shadow table and returns the result it yields.
  function automatic res_word_t cache_predict(op_word_t w);
    res_word_t r;
    int        i;
    int        hit_at;
    int        free_at;
    int        n_exp;
    r       = '0;
    hit_at  = -1;
    free_at = -1;
    n_exp   = 0;
    // lowest valid entry with a matching address, lowest free slot
    for (i = NENT - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_ip[i] == w.ip) hit_at = i;
      if (!shadow_valid[i]) free_at = i;
    end
    case (w.func)
      amc_pkg::FN_LOOKUP: begin
        if (hit_at >= 0) begin
          r.hit  = 1'b1;
          r.mac  = shadow_mac[hit_at];
          r.slot = hit_at[SLOT_W-1:0];
        end
      end
      amc_pkg::FN_INSERT: begin
        if (hit_at >= 0) begin
          i      = hit_at;
          r.kind = amc_pkg::KIND_UPDATE;
        end else if (free_at >= 0) begin
          i      = free_at;
          r.kind = amc_pkg::KIND_FILL;
          shadow_ip[i] = w.ip;
        end else begin
          i      = int'(w.victim) % NENT;
          r.kind = amc_pkg::KIND_VICTIM;
          shadow_ip[i] = w.ip;
        end
        shadow_mac[i]   = w.mac;
        shadow_age[i]   = '0;
        shadow_valid[i] = 1'b1;
        r.slot          = i[SLOT_W-1:0];
      end
      amc_pkg::FN_TICK: begin
        for (i = 0; i < NENT; i++) begin
          if (shadow_valid[i]) begin
            if (shadow_age[i] != 8'd255) shadow_age[i] = shadow_age[i] + 8'd1;
            if (shadow_age[i] > shadow_max_age) begin
              shadow_valid[i] = 1'b0;
              if (n_exp < 63) n_exp++;
            end
          end
        end
        r.expired = n_exp[EXP_W-1:0];
      end
      default: ;  // unused code: nothing changes, all zero
    endcase
    return r;
  endfunction

  // Random word: mostly addresses from a small pool so lookups hit and the
  // table fills; the rest fully random keys and the unused code as noise.
  function automatic op_word_t rand_word();
    op_word_t    w;
    logic [63:0] r64;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 42)      w.func = amc_pkg::FN_LOOKUP;
    else if (pick < 82) w.func = amc_pkg::FN_INSERT;
    else if (pick < 96) w.func = amc_pkg::FN_TICK;
    else                w.func = FN_UNUSED;
    if ($urandom_range(0, 99) < 85) w.ip = ip_pool[$urandom_range(0, POOL_SZ - 1)];
    else                            w.ip = $urandom;
    r64      = {$urandom, $urandom};
    w.mac    = r64[MAC_W-1:0];
    w.victim = VICT_W'($urandom_range(0, 31));
    return w;
  endfunction

  // Offers one word, holds it until accepted, then queues its expectation.
  task automatic send_word(input op_word_t w, input logic typed, input res_word_t typed_res);
    res_word_t pred;
    in_func         <= w.func;
    in_ip_addr      <= w.ip;
    in_mac_addr     <= w.mac;
    in_victim_index <= w.victim;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = cache_predict(w);   // shadow state moves on either way
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Sender idle time: bursts with no gap, mostly short gaps, a few long ones.
  task automatic sender_gap();
    int g;
    int pick;
    g = 0;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       tx_burst_left = $urandom_range(10, 30);
      else if (pick < 45) g = 0;
      else if (pick < 80) g = $urandom_range(1, 3);
      else if (pick < 95) g = $urandom_range(4, 15);
      else                g = $urandom_range(30, 120);
    end
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every queued result word has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_max_age(input logic [AGE_W-1:0] v);
    cfg_max_age <= v;
    cfg_valid   <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_max_age = v;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: checks each accepted result word and drives out_stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_res = {out_hit, out_mac_out, out_slot, out_insert_kind, out_expired_count};
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display({"ERROR: result word with none pending: ",
                    "hit=%0d mac=%h slot=%0d kind=%0d exp=%0d"},
                   got_res.hit, got_res.mac, got_res.slot, got_res.kind, got_res.expired);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.hit !== want_res.hit || got_res.mac !== want_res.mac ||
            got_res.slot !== want_res.slot || got_res.kind !== want_res.kind ||
            got_res.expired !== want_res.expired) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"ERROR: exp hit=%0d mac=%h slot=%0d kind=%0d exp=%0d",
                      " | got hit=%0d mac=%h slot=%0d kind=%0d exp=%0d"},
                     want_res.hit, want_res.mac, want_res.slot, want_res.kind,
                     want_res.expired, got_res.hit, got_res.mac, got_res.slot,
                     got_res.kind, got_res.expired);
        end
      end
    end

    // stall pattern: a requested long hold first, else random runs
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 45) begin
          rx_run_stall = 1'b0;
          rx_run_left  = $urandom_range(1, 40);
        end else if (rx_pick < 85) begin
          rx_run_stall = 1'b1;
          rx_run_left  = $urandom_range(1, 3);
        end else if (rx_pick < 97) begin
          rx_run_stall = 1'b1;
          rx_run_left  = $urandom_range(4, 20);
        end else begin
          rx_run_stall = 1'b1;
          rx_run_left  = $urandom_range(30, 80);
        end
      end
      rx_run_left--;
      out_stall <= rx_run_stall;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stim
    int          i;
    int          ph;
    int          n;
    logic [7:0]  phase_age;
    op_word_t    w;

    for (i = 0; i < NENT; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_ip[i]    = '0;
      shadow_mac[i]   = '0;
      shadow_age[i]   = '0;
    end
    shadow_max_age = amc_pkg::MAX_AGE_RESET;

    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (i = 2; i < POOL_SZ; i++) ip_pool[i] = $urandom;

    // Directed rows: typed results only where obvious (empty table, extremes,
    // unused code); the rest come from the shadow table.
    dir_tab[0]  = '{'{amc_pkg::FN_LOOKUP, 32'h0, 48'h0, 5'd0}, 1'b1,
                    '{1'b0, 48'h0, 5'd0, amc_pkg::KIND_NONE, 6'd0}};
    dir_tab[1]  = '{'{FN_UNUSED, 32'hFFFF_FFFF, MAC_ONES, 5'd31}, 1'b1,
                    '{1'b0, 48'h0, 5'd0, amc_pkg::KIND_NONE, 6'd0}};
    dir_tab[2]  = '{'{amc_pkg::FN_TICK, 32'h0, 48'h0, 5'd0}, 1'b1,
                    '{1'b0, 48'h0, 5'd0, amc_pkg::KIND_NONE, 6'd0}};
    dir_tab[3]  = '{'{amc_pkg::FN_INSERT, 32'hFFFF_FFFF, MAC_ONES, 5'd31}, 1'b1,
                    '{1'b0, 48'h0, 5'd0, amc_pkg::KIND_FILL, 6'd0}};
    dir_tab[4]  = '{'{amc_pkg::FN_INSERT, 32'h0, 48'h0, 5'd0}, 1'b1,
                    '{1'b0, 48'h0, 5'd1, amc_pkg::KIND_FILL, 6'd0}};
    dir_tab[5]  = '{'{amc_pkg::FN_LOOKUP, 32'hFFFF_FFFF, 48'h0, 5'd0}, 1'b1,
                    '{1'b1, MAC_ONES, 5'd0, amc_pkg::KIND_NONE, 6'd0}};
    dir_tab[6]  = '{'{amc_pkg::FN_LOOKUP, 32'h0, MAC_ONES, 5'd31}, 1'b1,
                    '{1'b1, 48'h0, 5'd1, amc_pkg::KIND_NONE, 6'd0}};
    dir_tab[7]  = '{'{amc_pkg::FN_INSERT, 32'hFFFF_FFFF, 48'h5555_AAAA_0F0F, 5'd7},
                    1'b0, '0};
    dir_tab[8]  = '{'{amc_pkg::FN_LOOKUP, 32'hFFFF_FFFF, 48'h0, 5'd0}, 1'b0, '0};
    dir_tab[9]  = '{'{amc_pkg::FN_INSERT, 32'hC0A8_0001, 48'hA5A5_5A5A_C3C3, 5'd16},
                    1'b0, '0};
    dir_tab[10] = '{'{amc_pkg::FN_LOOKUP, 32'hC0A8_0002, 48'h0, 5'd0}, 1'b0, '0};
    dir_tab[11] = '{'{amc_pkg::FN_TICK, 32'h0, 48'h0, 5'd0}, 1'b0, '0};
    dir_tab[12] = '{'{FN_UNUSED, 32'hC0A8_0001, 48'h1234_5678_9ABC, 5'd2}, 1'b1,
                    '{1'b0, 48'h0, 5'd0, amc_pkg::KIND_NONE, 6'd0}};
    dir_tab[13] = '{'{amc_pkg::FN_LOOKUP, 32'hC0A8_0001, 48'h0, 5'd0}, 1'b0, '0};
    dir_tab[14] = '{'{amc_pkg::FN_INSERT, 32'hC0A8_0001, 48'h0, 5'd0}, 1'b0, '0};

    // sync reset, applied only once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NDIR; i++) begin
      send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);
      sender_gap();
    end

    // Age saturation: with max_age 255 nothing expires even past 255 ticks;
    // dropping max_age to 254 then expires every entry sitting at 255.
    wait_results_done();
    write_max_age(8'd255);
    for (i = 0; i < 3; i++) begin
      w = rand_word();
      w.func = amc_pkg::FN_INSERT;
      w.ip   = ip_pool[i + 2];
      send_word(w, 1'b0, '0);
      sender_gap();
    end
    for (i = 0; i < SAT_TICKS; i++) begin
      w = rand_word();
      w.func = amc_pkg::FN_TICK;
      send_word(w, 1'b0, '0);
      sender_gap();
    end
    for (i = 0; i < 3; i++) begin
      w = rand_word();
      w.func = amc_pkg::FN_LOOKUP;
      w.ip   = ip_pool[i + 2];
      send_word(w, 1'b0, '0);
      sender_gap();
    end
    wait_results_done();
    write_max_age(8'd254);
    w = rand_word();
    w.func = amc_pkg::FN_TICK;
    send_word(w, 1'b0, '0);
    sender_gap();

    // Random phases, each under its own max_age: full table with victims,
    // instant expiry, short life, the reset value, anything.
    for (ph = 0; ph < NPHASE; ph++) begin
      case (ph)
        0:       phase_age = 8'd255;
        1:       phase_age = 8'd0;
        2:       phase_age = 8'($urandom_range(1, 6));
        3:       phase_age = amc_pkg::MAX_AGE_RESET;
        default: phase_age = 8'($urandom_range(0, 255));
      endcase
      wait_results_done();
      write_max_age(phase_age);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-offs while words keep coming
        if ((ph == 0 && n == 30) || (ph == 3 && n == 10)) hold_tgl <= ~hold_tgl;
        // one mid-phase pause until the pipe is empty
        if (ph == 2 && n == 50) wait_results_done();
        send_word(rand_word(), 1'b0, '0);
        sender_gap();
      end
    end

    wait_results_done();
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("address_map_cache_with_aging_unit_tb passed");
    end else begin
      $display("address_map_cache_with_aging_unit_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("address_map_cache_with_aging_unit_tb failed");
    $finish;
  end

endmodule

/* sim.f */
sv/amc_pkg.sv
sv/amc_ctrl.sv
sv/amc_dp.sv
sv/address_map_cache_with_aging_unit.sv
tb/address_map_cache_with_aging_unit_tb.sv
